/* sv/lcdns_pkg.sv */
// Shared types, codes and the init script for the character LCD write sequencer.
package lcdns_pkg;

    // Request codes as they arrive on the input side.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_MOVE  = 2'd2;
    localparam logic [1:0] REQ_INIT  = 2'd3;

    // Status codes returned with every result.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    // Cursor move command bases and nibble mask.
    localparam logic [7:0] LINE0_BASE  = 8'h80;
    localparam logic [7:0] LINE1_BASE  = 8'hC0;
    localparam logic [7:0] NIBBLE_MASK = 8'h0F;

    // Register defaults.
    localparam logic [15:0] PULSE_RESET = 16'd20;
    localparam logic [15:0] WAIT_RESET  = 16'd50;

    localparam logic [3:0] SCRIPT_LEN = 4'd9;

    // Queue depths, as address bits.
    localparam int CMD_ADDR_BITS = 2;
    localparam int RES_ADDR_BITS = 2;

    // Classified command passed from the front end to the sequencer.
    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_BYTE,
        CMD_INIT,
        CMD_BAD_MOVE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] byte_value;
        logic       is_data;
    } t_cmd;

    typedef struct packed {
        logic [3:0] lcd_nibble;
        logic       lcd_rs;
        logic       lcd_en;
        logic       busy_res;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        logic       is_wait;
        logic [7:0] byte_value;
    } t_script_entry;

    // Power-up script: wait, 33, 32, 28, 0E, 01, wait, 06, wait.
    function automatic t_script_entry f_script_entry(input logic [3:0] idx);
        t_script_entry e;
        e.is_wait    = 1'b0;
        e.byte_value = 8'h00;
        case (idx)
            4'd0: e.is_wait = 1'b1;
            4'd1: e.byte_value = 8'h33;
            4'd2: e.byte_value = 8'h32;
            4'd3: e.byte_value = 8'h28;
            4'd4: e.byte_value = 8'h0E;
            4'd5: e.byte_value = 8'h01;
            4'd6: e.is_wait = 1'b1;
            4'd7: e.byte_value = 8'h06;
            4'd8: e.is_wait = 1'b1;
            default: e.is_wait = 1'b1;
        endcase
        return e;
    endfunction

endpackage

/* sv/lcdns_fifo.sv */
// Small first-in first-out register queue used between the pipeline parts.
module lcdns_fifo #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);
    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WIDTH-1:0]   r_mem [DEPTH];
    logic [ADDR_BITS:0] r_wr_ptr;
    logic [ADDR_BITS:0] r_rd_ptr;

    assign o_empty   = (r_wr_ptr == r_rd_ptr);
    assign o_full    = (r_wr_ptr[ADDR_BITS] != r_rd_ptr[ADDR_BITS]) &&
                       (r_wr_ptr[ADDR_BITS-1:0] == r_rd_ptr[ADDR_BITS-1:0]);
    assign o_rd_data = r_mem[r_rd_ptr[ADDR_BITS-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_wr_en && !o_full) begin
            r_mem[r_wr_ptr[ADDR_BITS-1:0]] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_wr_en && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd_en && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

/* sv/lcdns_front.sv */
// Front end: accepts request beats and classifies them into sequencer commands.
module lcdns_front import lcdns_pkg::*; #(
    parameter int COLUMNS = 16
) (
    input  logic       i_push,
    input  logic       i_cmd_full,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_byte_value,
    input  logic       i_is_data,
    input  logic [7:0] i_line_number,
    input  logic [7:0] i_column,
    output logic       o_cmd_wr,
    output t_cmd       o_cmd
);
    localparam logic [7:0] COL_LIMIT = 8'(COLUMNS);

    logic [7:0] move_base;
    logic       move_bad;

    assign o_cmd_wr  = i_push && !i_cmd_full;
    assign move_base = (i_line_number == 8'd0) ? LINE0_BASE : LINE1_BASE;
    assign move_bad  = (i_line_number > 8'd1) || (i_column >= COL_LIMIT);

    always_comb begin
        o_cmd.kind       = CMD_TICK;
        o_cmd.byte_value = i_byte_value;
        o_cmd.is_data    = i_is_data;
        case (i_req_type)
            REQ_TICK: begin
                o_cmd.kind = CMD_TICK;
            end
            REQ_WRITE: begin
                o_cmd.kind = CMD_BYTE;
            end
            REQ_MOVE: begin
                // Cursor moves are always commands, never data.
                o_cmd.kind       = move_bad ? CMD_BAD_MOVE : CMD_BYTE;
                o_cmd.byte_value = move_base + i_column;
                o_cmd.is_data    = 1'b0;
            end
            REQ_INIT: begin
                o_cmd.kind = CMD_INIT;
            end
            default: begin
                o_cmd.kind = CMD_TICK;
            end
        endcase
    end

endmodule

/* sv/lcdns_back.sv */
// Back end: LCD pin nibble and init sequencer, one command a cycle while the result queue has room.
module lcdns_back import lcdns_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_cmd_empty,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    input  logic        i_res_full,
    output logic        o_res_push,
    output t_result     o_res
);
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HI_EN,
        PH_HI_LOW,
        PH_LO_EN,
        PH_LO_LOW,
        PH_WAIT
    } t_phase;

    t_phase        r_phase,      n_phase;
    logic [15:0]   r_wait_count, n_wait_count;
    logic [7:0]    r_held_byte,  n_held_byte;
    logic          r_held_sel,   n_held_sel;
    logic [3:0]    r_init_step,  n_init_step;
    logic [3:0]    r_pin_nibble, n_pin_nibble;
    logic          r_pin_sel,    n_pin_sel;
    logic          r_pin_en,     n_pin_en;
    logic [15:0]   r_pulse_ticks;
    logic [15:0]   r_init_wait_ticks;

    logic [15:0]   pulse_len;
    logic [15:0]   init_len;
    logic [3:0]    step_inc;
    logic          step_start;
    logic [3:0]    step_sel;
    t_script_entry entry;
    logic [1:0]    status;

    assign o_cmd_pop  = !i_cmd_empty && !i_res_full;
    assign o_res_push = o_cmd_pop;

    // A zero length register behaves as one tick.
    assign pulse_len = (r_pulse_ticks == 16'd0) ? 16'd1 : r_pulse_ticks;
    assign init_len  = (r_init_wait_ticks == 16'd0) ? 16'd1 : r_init_wait_ticks;
    assign step_inc  = r_init_step + 4'd1;

    always_comb begin
        n_phase      = r_phase;
        n_wait_count = r_wait_count;
        n_held_byte  = r_held_byte;
        n_held_sel   = r_held_sel;
        n_init_step  = r_init_step;
        n_pin_nibble = r_pin_nibble;
        n_pin_sel    = r_pin_sel;
        n_pin_en     = r_pin_en;
        status       = ST_OK;
        step_start   = 1'b0;
        step_sel     = 4'd0;

        if (i_cmd.kind == CMD_TICK) begin
            if (r_phase != PH_IDLE) begin
                if (r_wait_count > 16'd1) begin
                    n_wait_count = r_wait_count - 16'd1;
                end else begin
                    case (r_phase)
                        PH_HI_EN: begin
                            n_pin_en     = 1'b0;
                            n_phase      = PH_HI_LOW;
                            n_wait_count = pulse_len;
                        end
                        PH_HI_LOW: begin
                            n_pin_nibble = r_held_byte[3:0];
                            n_pin_en     = 1'b1;
                            n_phase      = PH_LO_EN;
                            n_wait_count = pulse_len;
                        end
                        PH_LO_EN: begin
                            n_pin_en     = 1'b0;
                            n_phase      = PH_LO_LOW;
                            n_wait_count = pulse_len;
                        end
                        PH_LO_LOW, PH_WAIT: begin
                            n_wait_count = 16'd0;
                            if (r_init_step != 4'd0 && step_inc <= SCRIPT_LEN) begin
                                step_start = 1'b1;
                                step_sel   = step_inc;
                            end else begin
                                n_init_step = 4'd0;
                                n_phase     = PH_IDLE;
                            end
                        end
                        default: begin
                            n_phase      = PH_IDLE;
                            n_wait_count = 16'd0;
                            n_init_step  = 4'd0;
                            n_pin_en     = 1'b0;
                        end
                    endcase
                end
            end
        end else if (r_phase != PH_IDLE) begin
            status = ST_BUSY;
        end else begin
            case (i_cmd.kind)
                CMD_BYTE: begin
                    n_held_byte  = i_cmd.byte_value;
                    n_held_sel   = i_cmd.is_data;
                    n_pin_nibble = i_cmd.byte_value[7:4];
                    n_pin_sel    = i_cmd.is_data;
                    n_pin_en     = 1'b1;
                    n_phase      = PH_HI_EN;
                    n_wait_count = pulse_len;
                end
                CMD_INIT: begin
                    step_start = 1'b1;
                    step_sel   = 4'd1;
                end
                CMD_BAD_MOVE: begin
                    status = ST_IGNORED;
                end
                default: begin
                    status = ST_OK;
                end
            endcase
        end

        // Start of a script entry: either a timed wait or a command byte.
        entry = f_script_entry(step_sel - 4'd1);
        if (step_start) begin
            n_init_step = step_sel;
            if (entry.is_wait) begin
                n_pin_en     = 1'b0;
                n_phase      = PH_WAIT;
                n_wait_count = init_len;
            end else begin
                n_held_byte  = entry.byte_value;
                n_held_sel   = 1'b0;
                n_pin_nibble = entry.byte_value[7:4];
                n_pin_sel    = 1'b0;
                n_pin_en     = 1'b1;
                n_phase      = PH_HI_EN;
                n_wait_count = pulse_len;
            end
        end
    end

    always_comb begin
        o_res.lcd_nibble = n_pin_nibble;
        o_res.lcd_rs     = n_pin_sel;
        o_res.lcd_en     = n_pin_en;
        o_res.busy_res   = (n_phase != PH_IDLE);
        o_res.status     = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_wait_count      <= 16'd0;
            r_held_byte       <= 8'd0;
            r_held_sel        <= 1'b0;
            r_init_step       <= 4'd0;
            r_pin_nibble      <= 4'd0;
            r_pin_sel         <= 1'b0;
            r_pin_en          <= 1'b0;
            r_pulse_ticks     <= PULSE_RESET;
            r_init_wait_ticks <= WAIT_RESET;
        end else begin
            if (o_cmd_pop) begin
                r_phase      <= n_phase;
                r_wait_count <= n_wait_count;
                r_held_byte  <= n_held_byte;
                r_held_sel   <= n_held_sel;
                r_init_step  <= n_init_step;
                r_pin_nibble <= n_pin_nibble;
                r_pin_sel    <= n_pin_sel;
                r_pin_en     <= n_pin_en;
            end
            if (i_cfg_wr_en) begin
                if (i_cfg_index) begin
                    r_init_wait_ticks <= i_cfg_data;
                end else begin
                    r_pulse_ticks <= i_cfg_data;
                end
            end
        end
    end

endmodule

/* sv/char_lcd_nibble_write_sequencer_core.sv */
// Top level of the character LCD 4-bit write sequencer.
//
// This block drives a character LCD of the common 4-bit bus kind. Each input beat is
// either a tick, which lets time pass, or a request: write one command or data byte,
// move the cursor (line 0 sends 0x80 plus the column, line 1 sends 0xC0 plus the
// column; other lines or columns not below COLUMNS are ignored with status 2), or run
// the power-up script (wait, 0x33, 0x32, 0x28, 0x0E, 0x01, wait, 0x06, wait). Every
// byte goes out high nibble first, EN high for pulse_ticks ticks and then low for
// pulse_ticks ticks. A request that arrives while a byte or the script is running is
// refused with status 1. Every input beat yields exactly one result beat that shows
// the pin levels, the busy flag and the status after that beat. A front end classifies
// each beat and writes it into a four-entry command queue; the sequencer behind it
// executes one command in every cycle while the result queue has room, and writes
// results into a four-entry result queue. The block therefore sustains one beat per
// clock cycle while results are popped. A result passes through the command queue and
// the result queue before it reaches the output ports, and is held up further when the
// consumer stops popping and the queues fill up. Register 0 is pulse_ticks (reset 20)
// and register 1 is init_wait_ticks (reset 50); a value of zero acts as one.
// Registers are to be written only while the block has no work outstanding.
module char_lcd_nibble_write_sequencer_core import lcdns_pkg::*; #(
    parameter int COLUMNS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Request side, queue style.
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_byte_value,
    input  logic        i_is_data,
    input  logic [7:0]  i_line_number,
    input  logic [7:0]  i_column,

    // Result side, queue style.
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_lcd_nibble,
    output logic        o_lcd_rs,
    output logic        o_lcd_en,
    output logic        o_busy_res,
    output logic [1:0]  o_status,

    // Configuration write port.
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    t_cmd    front_cmd;
    logic    front_wr;
    t_cmd    queued_cmd;
    logic    cmd_empty;
    logic    cmd_pop;
    t_result back_res;
    logic    res_push;
    logic    res_full;
    t_result out_res;

    // Classification of incoming beats.
    lcdns_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .i_push        (push),
        .i_cmd_full    (full),
        .i_req_type    (i_req_type),
        .i_byte_value  (i_byte_value),
        .i_is_data     (i_is_data),
        .i_line_number (i_line_number),
        .i_column      (i_column),
        .o_cmd_wr      (front_wr),
        .o_cmd         (front_cmd)
    );

    // The command queue decouples acceptance from execution; its full flag is
    // the block's full.
    lcdns_fifo #(
        .WIDTH     ($bits(t_cmd)),
        .ADDR_BITS (CMD_ADDR_BITS)
    ) u_cmd_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (front_wr),
        .i_wr_data (front_cmd),
        .o_full    (full),
        .i_rd_en   (cmd_pop),
        .o_rd_data (queued_cmd),
        .o_empty   (cmd_empty)
    );

    // The sequencer only advances when its result has somewhere to go, so
    // back-pressure on the result side simply holds commands in the queue.
    lcdns_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (queued_cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    lcdns_fifo #(
        .WIDTH     ($bits(t_result)),
        .ADDR_BITS (RES_ADDR_BITS)
    ) u_res_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (res_push),
        .i_wr_data (back_res),
        .o_full    (res_full),
        .i_rd_en   (pop),
        .o_rd_data (out_res),
        .o_empty   (empty)
    );

    assign o_lcd_nibble = out_res.lcd_nibble;
    assign o_lcd_rs     = out_res.lcd_rs;
    assign o_lcd_en     = out_res.lcd_en;
    assign o_busy_res   = out_res.busy_res;
    assign o_status     = out_res.status;

endmodule

/* sim/tb_char_lcd_nibble_write_sequencer_core.sv */
// Self-checking testbench for the character LCD 4-bit write sequencer core.
`timescale 1ns / 100ps

module tb_char_lcd_nibble_write_sequencer_core;

    import lcdns_pkg::*;

    // Register indexes on the configuration port.
    localparam logic REG_PULSE     = 1'b0;
    localparam logic REG_INIT_WAIT = 1'b1;

    localparam int LCD_COLUMNS  = 16;
    localparam int RANDOM_BEATS = 1100;
    // Cycles without any handshake or register write before the run is declared hung.
    localparam int QUIET_LIMIT  = 2000;
    // Marks a wait step in the power-up script rather than a byte to send.
    localparam logic [8:0] WAIT_MARK = 9'h100;

    // One request beat as it is presented on the input side.
    typedef struct packed {
        logic [1:0] req;
        logic [7:0] byte_value;
        logic       is_data;
        logic [7:0] line_number;
        logic [7:0] column;
    } t_lcd_req;

    // Where the bus sequencer is within one byte, or in a script wait.
    typedef enum logic [2:0] {
        BUS_IDLE,
        BUS_HI_EN,
        BUS_HI_LOW,
        BUS_LO_EN,
        BUS_LO_LOW,
        BUS_WAIT
    } t_bus_phase;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        push          = 1'b0;
    logic [1:0]  i_req_type    = REQ_TICK;
    logic [7:0]  i_byte_value  = 8'h00;
    logic        i_is_data     = 1'b0;
    logic [7:0]  i_line_number = 8'h00;
    logic [7:0]  i_column      = 8'h00;
    logic        pop           = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic        i_cfg_index   = REG_PULSE;
    logic [15:0] i_cfg_data    = 16'h0000;

    logic        full;
    logic        empty;
    logic [3:0]  o_lcd_nibble;
    logic        o_lcd_rs;
    logic        o_lcd_en;
    logic        o_busy_res;
    logic [1:0]  o_status;

    char_lcd_nibble_write_sequencer_core #(
        .COLUMNS(LCD_COLUMNS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_byte_value (i_byte_value),
        .i_is_data    (i_is_data),
        .i_line_number(i_line_number),
        .i_column     (i_column),
        .empty        (empty),
        .pop          (pop),
        .o_lcd_nibble (o_lcd_nibble),
        .o_lcd_rs     (o_lcd_rs),
        .o_lcd_en     (o_lcd_en),
        .o_busy_res   (o_busy_res),
        .o_status     (o_status),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Shadow of the sequencer. Register values are held here as well so
    // that the tick counts of each phase can be worked out independently.
    // ------------------------------------------------------------------
    logic [15:0] cfg_pulse   = PULSE_RESET;
    logic [15:0] cfg_wait    = WAIT_RESET;
    t_bus_phase  bus_phase   = BUS_IDLE;
    logic [15:0] phase_left  = 16'd0;
    logic [7:0]  shadow_byte = 8'h00;
    logic        shadow_rs   = 1'b0;
    logic [3:0]  script_pos  = 4'd0;     // zero means no script running
    logic [3:0]  pin_d       = 4'd0;
    logic        pin_rs      = 1'b0;
    logic        pin_e       = 1'b0;

    t_lcd_req pending_reqs[$];      // beats still to be driven
    t_result  expected_pins[$];     // predicted result beats, oldest first
    int       queued_beats = 0;
    int       error_count  = 0;

    // A length register of zero behaves as one.
    function automatic logic [15:0] nonzero(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // The power-up script: wait, 33, 32, 28, 0E, 01, wait, 06, wait.
    function automatic logic [8:0] power_up_step(input logic [3:0] idx);
        case (idx)
            4'd1:    return 9'h033;
            4'd2:    return 9'h032;
            4'd3:    return 9'h028;
            4'd4:    return 9'h00E;
            4'd5:    return 9'h001;
            4'd7:    return 9'h006;
            default: return WAIT_MARK;
        endcase
    endfunction

    // A byte starts with its high nibble on the bus and EN raised at once.
    function automatic void load_byte(input logic [7:0] b, input logic rs);
        shadow_byte = b;
        shadow_rs   = rs;
        pin_d       = b[7:4];
        pin_rs      = rs;
        pin_e       = 1'b1;
        bus_phase   = BUS_HI_EN;
        phase_left  = nonzero(cfg_pulse);
    endfunction

    function automatic void enter_script_step();
        logic [8:0] entry;
        if (script_pos == 4'd0 || script_pos > SCRIPT_LEN) begin
            script_pos = 4'd0;
            bus_phase  = BUS_IDLE;
        end else begin
            entry = power_up_step(script_pos - 4'd1);
            if (entry[8]) begin
                pin_e      = 1'b0;
                bus_phase  = BUS_WAIT;
                phase_left = nonzero(cfg_wait);
            end else begin
                load_byte(entry[7:0], 1'b0);
            end
        end
    endfunction

    // A byte or a wait has finished: either move along the script or go idle.
    function automatic void finish_step();
        if (script_pos != 4'd0) begin
            script_pos = script_pos + 4'd1;
            if (script_pos > SCRIPT_LEN) begin
                script_pos = 4'd0;
                bus_phase  = BUS_IDLE;
            end else begin
                enter_script_step();
            end
        end else begin
            bus_phase = BUS_IDLE;
        end
    endfunction

    // Only tick beats let time pass; the next phase starts on the tick that
    // completes the current one.
    function automatic void advance_tick();
        if (bus_phase != BUS_IDLE) begin
            if (phase_left > 16'd1) begin
                phase_left = phase_left - 16'd1;
            end else begin
                case (bus_phase)
                    BUS_HI_EN: begin
                        pin_e      = 1'b0;
                        bus_phase  = BUS_HI_LOW;
                        phase_left = nonzero(cfg_pulse);
                    end
                    BUS_HI_LOW: begin
                        pin_d      = shadow_byte[3:0];
                        pin_e      = 1'b1;
                        bus_phase  = BUS_LO_EN;
                        phase_left = nonzero(cfg_pulse);
                    end
                    BUS_LO_EN: begin
                        pin_e      = 1'b0;
                        bus_phase  = BUS_LO_LOW;
                        phase_left = nonzero(cfg_pulse);
                    end
                    default: begin
                        phase_left = 16'd0;
                        finish_step();
                    end
                endcase
            end
        end
    endfunction

    // Applies one accepted request beat to the shadow and returns the pins,
    // busy flag and status that the block must report for it.
    function automatic t_result predict_beat(input t_lcd_req it);
        t_result    r;
        logic [1:0] st;
        logic       was_busy;
        was_busy = (bus_phase != BUS_IDLE);
        st       = ST_OK;
        if (it.req == REQ_TICK) begin
            advance_tick();
        end else if (was_busy) begin
            st = ST_BUSY;
        end else if (it.req == REQ_WRITE) begin
            load_byte(it.byte_value, it.is_data);
        end else if (it.req == REQ_MOVE) begin
            if (it.line_number > 8'd1 || it.column >= 8'(LCD_COLUMNS)) begin
                st = ST_IGNORED;
            end else begin
                load_byte(((it.line_number == 8'd0) ? LINE0_BASE : LINE1_BASE) + it.column,
                          1'b0);
            end
        end else begin
            script_pos = 4'd1;
            enter_script_step();
        end
        r.lcd_nibble = pin_d;
        r.lcd_rs     = pin_rs;
        r.lcd_en     = pin_e;
        r.busy_res   = (bus_phase != BUS_IDLE);
        r.status     = st;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction. Everything here runs in zero time and only
    // appends to the pending queue that the driver drains.
    // ------------------------------------------------------------------
    function automatic void add_item(input logic [1:0] req, input logic [7:0] bv,
                                     input logic isd, input logic [7:0] ln,
                                     input logic [7:0] col);
        t_lcd_req it;
        it.req         = req;
        it.byte_value  = bv;
        it.is_data     = isd;
        it.line_number = ln;
        it.column      = col;
        pending_reqs.push_back(it);
        queued_beats++;
    endfunction

    // Tick beats carry random junk in the other fields. When noisy, requests
    // are sprinkled in, which are mostly refused because a byte is under way.
    function automatic void add_ticks(input int n, input bit noisy);
        for (int k = 0; k < n; k++) begin
            if (noisy && $urandom_range(0, 11) == 0)
                add_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
            add_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
    endfunction

    // One well-formed sequence: a request followed by about enough ticks to
    // complete it, sometimes cut short so that the next request is refused.
    function automatic void add_sequence();
        int pick;
        int needed;
        int n_ticks;
        int p;
        int w;
        p      = int'(nonzero(cfg_pulse));
        w      = int'(nonzero(cfg_wait));
        pick   = $urandom_range(0, 99);
        needed = 0;
        if (pick < 40) begin
            add_item(REQ_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            needed = 4 * p;
        end else if (pick < 62) begin
            if ($urandom_range(0, 4) != 0) begin
                add_item(REQ_MOVE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 1)), 8'($urandom_range(0, LCD_COLUMNS - 1)));
                needed = 4 * p;
            end else if ($urandom_range(0, 1) == 0) begin
                add_item(REQ_MOVE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
            end else begin
                add_item(REQ_MOVE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 1)), 8'($urandom_range(LCD_COLUMNS, 255)));
            end
        end else if (pick < 72) begin
            add_item(REQ_INIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            needed = 3 * w + 24 * p;
        end else if (pick >= 85) begin
            add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) < 7)
            n_ticks = needed + $urandom_range(0, 2);
        else
            n_ticks = $urandom_range(0, needed + 2);
        add_ticks(n_ticks, 1'b1);
    endfunction

    function automatic logic [15:0] pick_setting();
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'd1;
            default: return 16'($urandom_range(2, 6));
        endcase
    endfunction

    // Register writes happen only while the handshake is quiet, so the
    // shadow copy can be updated straight away.
    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        if (idx == REG_PULSE)
            cfg_pulse = value;
        else
            cfg_wait = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Holds the sender back until every queued beat has gone in and every
    // predicted result has come out. Checked on the falling edge so that the
    // driver's and monitor's updates of the rising edge have all landed.
    task automatic settle();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || push || expected_pins.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents pending beats in bursts of random length separated
    // by random gaps, holding a beat steady while full is high.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;
    t_lcd_req next_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            // The beat on the ports is taken at this edge: predict its result.
            if (push && !full)
                expected_pins.push_back(predict_beat({i_req_type, i_byte_value, i_is_data,
                                                      i_line_number, i_column}));
            if (!(push && full)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    next_req = pending_reqs.pop_front();
                    i_req_type    <= next_req.req;
                    i_byte_value  <= next_req.byte_value;
                    i_is_data     <= next_req.is_data;
                    i_line_number <= next_req.line_number;
                    i_column      <= next_req.column;
                    push          <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 3))
                            0:       gap_left = $urandom_range(1, 3);
                            1:       gap_left = $urandom_range(4, 12);
                            default: gap_left = 0;
                        endcase
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes result beats and checks each field against the oldest
    // prediction. The pop pattern is repeatedly redrawn at random from always
    // ready, random stalls, a short periodic stall and long stalls that let
    // the result queue fill and push back on the sender.
    // ------------------------------------------------------------------
    int unsigned rx_cycle = 0;
    int          rx_mode  = 0;
    logic        want_pop;
    t_result     want;

    function automatic void check_field(input string field, input logic [3:0] exp_v,
                                        input logic [3:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", field, exp_v, got_v);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_pins.size() == 0) begin
                    $error("result beat arrived with no prediction waiting");
                    error_count++;
                end else begin
                    want = expected_pins.pop_front();
                    check_field("lcd_nibble", want.lcd_nibble, o_lcd_nibble);
                    check_field("lcd_rs", 4'(want.lcd_rs), 4'(o_lcd_rs));
                    check_field("lcd_en", 4'(want.lcd_en), 4'(o_lcd_en));
                    check_field("busy_res", 4'(want.busy_res), 4'(o_busy_res));
                    check_field("status", 4'(want.status), 4'(o_status));
                end
            end
            rx_cycle++;
            if (rx_cycle % 97 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       want_pop = 1'b1;
                1:       want_pop = ($urandom_range(0, 2) != 0);
                2:       want_pop = ((rx_cycle % 7) >= 3);
                default: want_pop = ((rx_cycle % 32) >= 26);
            endcase
            pop <= want_pop;
        end
    end

    // Watchdog: any handshake or register write counts as progress.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_char_lcd_nibble_write_sequencer_core: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    int directed_beats;

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A pulse length of zero must behave as one tick, so
        // every byte below takes exactly four ticks.
        write_reg(REG_PULSE, 16'd0);
        write_reg(REG_INIT_WAIT, 16'd1);
        // A tick while idle changes nothing, whatever the other fields hold.
        add_item(REQ_TICK, 8'hFF, 1'b1, 8'hFF, 8'hFF);
        add_item(REQ_WRITE, 8'h00, 1'b0, 8'h00, 8'h00);
        add_ticks(4, 1'b0);
        // While busy, even an out-of-range cursor move is refused rather
        // than ignored, and so is an init request.
        add_item(REQ_WRITE, 8'hFF, 1'b1, 8'h00, 8'h00);
        add_item(REQ_MOVE, 8'h00, 1'b0, 8'hFF, 8'hFF);
        add_item(REQ_INIT, 8'h00, 1'b0, 8'h00, 8'h00);
        add_ticks(4, 1'b0);
        add_item(REQ_MOVE, 8'h00, 1'b1, 8'd0, 8'd15);
        add_ticks(4, 1'b0);
        add_item(REQ_MOVE, 8'hFF, 1'b1, 8'd1, 8'd0);
        add_ticks(4, 1'b0);
        // Bad cursor moves while idle: wrong line, column just past the end,
        // and both at their maximum.
        add_item(REQ_MOVE, 8'h00, 1'b0, 8'd2, 8'd0);
        add_item(REQ_MOVE, 8'h00, 1'b0, 8'd0, 8'd16);
        add_item(REQ_MOVE, 8'h00, 1'b0, 8'd255, 8'd255);
        settle();

        // Whole power-up script with a zero wait length and single-tick pulses.
        write_reg(REG_PULSE, 16'd1);
        write_reg(REG_INIT_WAIT, 16'd0);
        add_item(REQ_INIT, 8'h00, 1'b0, 8'h00, 8'h00);
        add_item(REQ_WRITE, 8'hAA, 1'b1, 8'h00, 8'h00);
        add_ticks(3 + 24 + 1, 1'b0);
        directed_beats = queued_beats;

        // Random part: phases of well-formed sequences, each with its own
        // register settings and a full drain in between.
        while (queued_beats - directed_beats < RANDOM_BEATS) begin
            settle();
            write_reg(REG_PULSE, pick_setting());
            write_reg(REG_INIT_WAIT, pick_setting());
            repeat ($urandom_range(15, 35)) add_sequence();
        end

        // The longest pulse: the first EN-high phase counts down from 65535.
        // The run ends with that phase still counting, so only the start of
        // the byte and the refusals of later requests are seen.
        settle();
        write_reg(REG_PULSE, 16'hFFFF);
        add_item(REQ_WRITE, 8'hA5, 1'b1, 8'h00, 8'h00);
        add_ticks(100, 1'b1);
        settle();
        repeat (8) @(posedge i_clk);

        if (error_count == 0 && expected_pins.size() == 0)
            $display("tb_char_lcd_nibble_write_sequencer_core: clean");
        else
            $display("tb_char_lcd_nibble_write_sequencer_core: errors");
        $finish;
    end

endmodule

/* char_lcd_nibble_write_sequencer_core.f */
sv/lcdns_pkg.sv
sv/lcdns_fifo.sv
sv/lcdns_front.sv
sv/lcdns_back.sv
sv/char_lcd_nibble_write_sequencer_core.sv
sim/tb_char_lcd_nibble_write_sequencer_core.sv
